[rtl/aset_pkg.sv]
// shared constants, command codes, state encoding and cell control type for the set table
package aset_pkg;

  localparam int CAPACITY    = 64;
  localparam int ELEM_W      = 32;
  localparam int VALUE_W     = 32;
  localparam int CMD_W       = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic             append;
    logic             shift;
    logic [IDX_W-1:0] slot;
  } cell_ctl_t;

endpackage

[rtl/aset_cell.sv]
// one storage cell: holds an entry, compares it to the key, shifts down or loads on command
module aset_cell (
  input  logic                         clk_i,
  input  logic [aset_pkg::IDX_W-1:0]   idx_i,
  input  logic [aset_pkg::CNT_W-1:0]   cnt_i,
  input  logic [aset_pkg::ELEM_W-1:0]  key_i,
  input  logic [aset_pkg::ELEM_W-1:0]  nbr_i,
  input  aset_pkg::cell_ctl_t          ctl_i,
  output logic [aset_pkg::ELEM_W-1:0]  value_o,
  output logic                         hit_o
);
  import aset_pkg::*;

  logic [ELEM_W-1:0] value_q;
  logic [ELEM_W-1:0] value_d;
  logic              in_use;

  assign in_use  = CNT_W'(idx_i) < cnt_i;
  assign hit_o   = in_use && (value_q == key_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctl_i.shift && (idx_i >= ctl_i.slot)) begin
      value_d = nbr_i;
    end else if (ctl_i.append && (CNT_W'(idx_i) == cnt_i)) begin
      value_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

[rtl/aset_enc.sv]
// one-hot match vector to slot index and any-match flag
module aset_enc (
  input  logic [aset_pkg::CAPACITY-1:0] hit_i,
  output logic [aset_pkg::IDX_W-1:0]    slot_o,
  output logic                          any_o
);
  import aset_pkg::*;

  always_comb begin
    slot_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_i[i]) begin
        slot_o = slot_o | IDX_W'(i);
      end
    end
  end

  assign any_o = |hit_i;

endmodule

[rtl/array_set_membership_table.sv]
// top level of the set table: command sequencer, cell chain and result register
//
// usage
//   input channel: a beat carries cmd_i (add, remove, search) and value_i; it is
//   taken on a rising edge with in_valid_i high and in_stall_o low
//   output channel: one result beat per command, ok_o, full_reject_o, count_o and
//   empty_res_o, taken on a rising edge with out_valid_o high and out_stall_i low
//   steps: each command passes a compare step and then an update step; the
//   compare step lets every cell compare its entry with the key in parallel
//   and encodes the match position, the update step appends at the tail or
//   shifts the cells above the match down by one and loads the result
//   register
//   a new command is taken while idle or in the same cycle that the previous
//   result is loaded, so a held result stalls a command only in its update step
//   stall: while a result is held the block finishes its compare and then
//   waits with the update; in_stall_o stays high until the result can be loaded
//   reset: the count goes to zero, the sequencer to idle and out_valid_o low;
//   entry contents stay as they are, only entries below the count are compared
module array_set_membership_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [aset_pkg::CMD_W-1:0]        cmd_i,
  input  logic [aset_pkg::VALUE_W-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic                              full_reject_o,
  output logic [aset_pkg::COUNT_OUT_W-1:0]  count_o,
  output logic                              empty_res_o
);
  import aset_pkg::*;

  // sequencer and command registers
  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q;
  logic [ELEM_W-1:0]  key_q;
  logic [CNT_W-1:0]   count_q, count_d;

  // compare results held for the update cycle
  logic               any_q;
  logic [IDX_W-1:0]   slot_q;
  logic [IDX_W-1:0]   slot_c;
  logic               any_c;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic                   ok_q, ok_d;
  logic                   rej_q, rej_d;
  logic [COUNT_OUT_W-1:0] cnt_out_q;
  logic                   empty_q;

  logic               in_fire;
  logic               out_free;
  logic               upd_go;
  cell_ctl_t          ctl;

  // cell chain wiring
  logic [ELEM_W-1:0]   vals [CAPACITY];
  logic [ELEM_W-1:0]   nbrs [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign upd_go     = (state_q == ST_UPD) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || upd_go);
  assign in_fire    = in_valid_i && !in_stall_o;

  // on a shift each cell at or above the match slot takes its upper neighbor's entry; the top cell keeps its own
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_top
      assign nbrs[i] = vals[i];
    end else begin : g_mid
      assign nbrs[i] = vals[i+1];
    end

    aset_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cnt_i   (count_q),
      .key_i   (key_q),
      .nbr_i   (nbrs[i]),
      .ctl_i   (ctl),
      .value_o (vals[i]),
      .hit_o   (hit_vec[i])
    );
  end

  aset_enc u_enc (
    .hit_i  (hit_vec),
    .slot_o (slot_c),
    .any_o  (any_c)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          state_d = in_valid_i ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // update decisions and result values
  always_comb begin
    ctl.append = 1'b0;
    ctl.shift  = 1'b0;
    ctl.slot   = slot_q;
    count_d    = count_q;
    ok_d       = 1'b0;
    rej_d      = 1'b0;
    if (upd_go) begin
      unique case (cmd_q)
        CMD_ADD: begin
          if (!any_q) begin
            if (count_q < CNT_W'(CAPACITY)) begin
              ctl.append = 1'b1;
              count_d    = count_q + CNT_W'(1);
              ok_d       = 1'b1;
            end else begin
              rej_d = 1'b1;
            end
          end
        end
        CMD_REMOVE: begin
          if (any_q) begin
            ctl.shift = 1'b1;
            count_d   = count_q - CNT_W'(1);
            ok_d      = 1'b1;
          end
        end
        CMD_SEARCH: begin
          ok_d = any_q;
        end
        default: begin
          // unused code: no change, no flags
        end
      endcase
    end
  end

  // result beat leaves when taken, a new one is loaded at the end of an update
  always_comb begin
    out_valid_d = out_valid_q;
    if (upd_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      key_q <= ELEM_W'(value_i);
    end
    if (state_q == ST_CMP) begin
      any_q  <= any_c;
      slot_q <= slot_c;
    end
    if (upd_go) begin
      ok_q      <= ok_d;
      rej_q     <= rej_d;
      cnt_out_q <= COUNT_OUT_W'(count_d);
      empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign full_reject_o = rej_q;
  assign count_o       = cnt_out_q;
  assign empty_res_o   = empty_q;

  // stored values are distinct, so at most one live cell can match
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result appeared without an update cycle");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(ok_q && rej_q))
    else $error("ok and full reject both set");

endmodule
